### sv/orm_pkg.sv
// Shared types, widths and codes for the outstanding request matcher.
// No dependencies; every other file in the project imports this package.
package orm_pkg;

    // Field widths fixed by the interface.
    localparam int CTX_W      = 32;
    localparam int TAG_W      = 16;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 5;
    localparam int RING_W     = 5;

    // Table geometry.
    localparam int DEPTH_DEFAULT = 16;
    localparam int MAX_SLOTS     = 16;
    localparam logic [RING_W-1:0] RING_RESET = RING_W'(16);

    // Classified item queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_NORESP   = 3'd2,
        ST_OK       = 3'd3,
        ST_NOMATCH  = 3'd4
    } status_t;

    // One classified input item; fields that do not apply are zeroed.
    typedef struct packed {
        logic             is_response;
        logic [CTX_W-1:0] ctx;
        logic             dump;
        logic             ping;
        logic [TAG_W-1:0] tag;
    } item_t;

    // Ring set-up handed to the back part.
    typedef struct packed {
        logic               clear;
        logic [COUNT_W-1:0] slots;
    } ring_ctrl_t;

    // Back part sequencer states.
    typedef enum logic {
        BK_IDLE,
        BK_WALK
    } back_state_t;

endpackage

### sv/orm_front.sv
// Front part: accepts input items, classifies them and queues them.
// Depends on orm_pkg for the item type and queue sizing.
module orm_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       mode,
    input  logic [orm_pkg::CTX_W-1:0]  context_req,
    input  logic                       is_dump,
    input  logic                       is_ping_reply,
    input  logic [orm_pkg::TAG_W-1:0]  request_tag,
    output logic                       q_valid,
    input  logic                       q_ready,
    output orm_pkg::item_t             q_item
);
    import orm_pkg::*;

    item_t               fifo_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    item_t               cls_item;
    logic                push;
    logic                pop;

    // Classify: a store keeps dump and tag, a response keeps the ping flag.
    always_comb
    begin
        cls_item.is_response = mode;
        cls_item.ctx         = context_req;
        cls_item.dump        = mode ? 1'b0 : is_dump;
        cls_item.ping        = mode ? is_ping_reply : 1'b0;
        cls_item.tag         = mode ? '0 : request_tag;
    end

    assign in_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = fifo_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage carries payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cls_item;
        end
    end

endmodule

### sv/orm_back.sv
// Back part: the circular request table, the match search and the retire walk.
// Depends on orm_pkg for types, widths and status codes.
module orm_back
#(
    parameter int DEPTH = orm_pkg::DEPTH_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  orm_pkg::ring_ctrl_t           ring,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  orm_pkg::item_t                q_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [orm_pkg::STATUS_W-1:0]  status,
    output logic [orm_pkg::TAG_W-1:0]     result_tag,
    output logic                          request_done,
    output logic [orm_pkg::COUNT_W-1:0]   pending_count,
    output logic                          last_result
);
    import orm_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int SUM_W = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 1;

    // Table storage, valid only where occupied.
    logic [CTX_W-1:0]   ctx_mem  [DEPTH];
    logic               dump_mem [DEPTH];
    logic [TAG_W-1:0]   tag_mem  [DEPTH];

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [IDX_W-1:0]   oldest_reg;
    logic [IDX_W-1:0]   oldest_next;
    logic [COUNT_W-1:0] occ_reg;
    logic [COUNT_W-1:0] occ_next;
    logic [DEPTH-1:0]   match_reg;
    logic [DEPTH-1:0]   match_next;
    logic               any_reg;
    logic               any_next;
    logic               ping_reg;
    logic               ping_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    status_t            out_status_reg;
    status_t            out_status_next;
    logic [TAG_W-1:0]   out_tag_reg;
    logic [TAG_W-1:0]   out_tag_next;
    logic               out_done_reg;
    logic               out_done_next;
    logic [COUNT_W-1:0] out_pend_reg;
    logic [COUNT_W-1:0] out_pend_next;
    logic               out_last_reg;
    logic               out_last_next;

    logic               out_free;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [DEPTH-1:0]   hit_vec;
    logic [IDX_W-1:0]   adv_idx;
    logic               is_full;
    logic               ok_done;

    assign out_free = !out_valid_reg || out_ready;
    assign is_full  = (occ_reg >= ring.slots);

    // Slot for a new entry, and the slot after the oldest, both modulo the ring size.
    always_comb
    begin
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] adv;
        sum = SUM_W'(oldest_reg) + SUM_W'(occ_reg);
        if (sum >= SUM_W'(ring.slots))
        begin
            sum = sum - SUM_W'(ring.slots);
        end
        wr_idx = sum[IDX_W-1:0];
        adv = SUM_W'(oldest_reg) + SUM_W'(1);
        if (adv >= SUM_W'(ring.slots))
        begin
            adv = '0;
        end
        adv_idx = adv[IDX_W-1:0];
    end

    // Parallel compare against every slot, masked to the occupied ones.
    always_comb
    begin
        logic [SUM_W-1:0] jj;
        logic [SUM_W-1:0] old;
        logic [SUM_W-1:0] rel;
        for (int j = 0; j < DEPTH; j++)
        begin
            jj  = SUM_W'(j);
            old = SUM_W'(oldest_reg);
            rel = (jj >= old) ? (jj - old) : (jj + SUM_W'(ring.slots) - old);
            hit_vec[j] = (jj < SUM_W'(ring.slots)) && (rel < SUM_W'(occ_reg))
                         && (ctx_mem[j] == q_item.ctx);
        end
    end

    // A dump entry stays open unless the response is the ping reply.
    assign ok_done = !(dump_mem[oldest_reg] && !ping_reg);

    // Sequencer: stores in one step, responses search then walk from the oldest.
    always_comb
    begin
        state_next      = state_reg;
        oldest_next     = oldest_reg;
        occ_next        = occ_reg;
        match_next      = match_reg;
        any_next        = any_reg;
        ping_next       = ping_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_tag_next    = out_tag_reg;
        out_done_next   = out_done_reg;
        out_pend_next   = out_pend_reg;
        out_last_next   = out_last_reg;
        q_ready         = 1'b0;
        wr_en           = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && !q_item.is_response)
                begin
                    if (out_free)
                    begin
                        q_ready        = 1'b1;
                        out_valid_next = 1'b1;
                        out_tag_next   = q_item.tag;
                        out_done_next  = 1'b0;
                        out_last_next  = 1'b1;
                        if (is_full)
                        begin
                            out_status_next = ST_FULL;
                            out_pend_next   = occ_reg;
                        end
                        else
                        begin
                            wr_en           = 1'b1;
                            occ_next        = occ_reg + 1'b1;
                            out_status_next = ST_ACCEPTED;
                            out_pend_next   = occ_reg + 1'b1;
                        end
                    end
                end
                else if (q_valid)
                begin
                    q_ready    = 1'b1;
                    match_next = hit_vec;
                    any_next   = |hit_vec;
                    ping_next  = q_item.ping;
                    state_next = BK_WALK;
                end
            end
            BK_WALK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (!any_reg)
                    begin
                        out_status_next = ST_NOMATCH;
                        out_tag_next    = '0;
                        out_done_next   = 1'b0;
                        out_pend_next   = occ_reg;
                        out_last_next   = 1'b1;
                        state_next      = BK_IDLE;
                    end
                    else if (match_reg[oldest_reg])
                    begin
                        out_status_next = ST_OK;
                        out_tag_next    = tag_mem[oldest_reg];
                        out_done_next   = ok_done;
                        out_last_next   = 1'b1;
                        out_pend_next   = ok_done ? (occ_reg - 1'b1) : occ_reg;
                        if (ok_done)
                        begin
                            oldest_next = adv_idx;
                            occ_next    = occ_reg - 1'b1;
                        end
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        out_status_next = ST_NORESP;
                        out_tag_next    = tag_mem[oldest_reg];
                        out_done_next   = 1'b1;
                        out_pend_next   = occ_reg - 1'b1;
                        out_last_next   = 1'b0;
                        oldest_next     = adv_idx;
                        occ_next        = occ_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        // A new ring set-up empties the table; the user must send it only while idle.
        if (ring.clear)
        begin
            oldest_next = '0;
            occ_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            oldest_reg    <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Search results and the output payload need no reset.
    always_ff @(posedge clk)
    begin
        match_reg      <= match_next;
        any_reg        <= any_next;
        ping_reg       <= ping_next;
        out_status_reg <= out_status_next;
        out_tag_reg    <= out_tag_next;
        out_done_reg   <= out_done_next;
        out_pend_reg   <= out_pend_next;
        out_last_reg   <= out_last_next;
    end

    // Table write for an accepted store.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ctx_mem[wr_idx]  <= q_item.ctx;
            dump_mem[wr_idx] <= q_item.dump;
            tag_mem[wr_idx]  <= q_item.tag;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign result_tag    = out_tag_reg;
    assign request_done  = out_done_reg;
    assign pending_count = out_pend_reg;
    assign last_result   = out_last_reg;

endmodule

### sv/outstanding_request_matcher.sv
// Top level of the outstanding request matcher: ring size register and the
// front and back parts. Depends on orm_pkg, orm_front and orm_back.
//
// The block tracks requests that wait for an answer in a circular table,
// oldest first. A store item yields one result (accepted or full). A
// response item is compared against every occupied slot in parallel,
// after which the back part walks from the oldest entry, giving one
// result per cycle while the output is not stalled: a no-response result
// for each older entry it retires and then the ok result, or a single
// no-match result. Each item first passes through the input queue; the
// back part then handles a store in its idle state, and a response by a
// registered compare followed by the retire walk, with every result held
// in the output register. Writing ring_size empties the table and must
// only be done while the block is idle; it takes effect on the next cycle.
module outstanding_request_matcher
#(
    parameter int DEPTH = orm_pkg::DEPTH_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [orm_pkg::RING_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [orm_pkg::CTX_W-1:0]     context_req,
    input  logic                          is_dump,
    input  logic                          is_ping_reply,
    input  logic [orm_pkg::TAG_W-1:0]     request_tag,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [orm_pkg::STATUS_W-1:0]  status,
    output logic [orm_pkg::TAG_W-1:0]     result_tag,
    output logic                          request_done,
    output logic [orm_pkg::COUNT_W-1:0]   pending_count,
    output logic                          last_result
);
    import orm_pkg::*;

    localparam int SLOT_LIMIT = (DEPTH < MAX_SLOTS) ? DEPTH : MAX_SLOTS;

    logic [RING_W-1:0] ring_size_reg;
    logic [RING_W-1:0] ring_size_next;
    logic              cfg_write;
    ring_ctrl_t        ring;
    logic              q_valid;
    logic              q_ready;
    item_t             q_item;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Ring size register.
    always_comb
    begin
        ring_size_next = cfg_write ? cfg_data : ring_size_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_size_reg <= RING_RESET;
        end
        else
        begin
            ring_size_reg <= ring_size_next;
        end
    end

    // Slots in use: zero counts as one, and the table size and MAX_SLOTS cap it.
    always_comb
    begin
        ring.clear = cfg_write;
        if (ring_size_reg == '0)
        begin
            ring.slots = COUNT_W'(1);
        end
        else if (COUNT_W'(ring_size_reg) > COUNT_W'(SLOT_LIMIT))
        begin
            ring.slots = COUNT_W'(SLOT_LIMIT);
        end
        else
        begin
            ring.slots = COUNT_W'(ring_size_reg);
        end
    end

    orm_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .context_req   (context_req),
        .is_dump       (is_dump),
        .is_ping_reply (is_ping_reply),
        .request_tag   (request_tag),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    orm_back
    #(
        .DEPTH (DEPTH)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ring          (ring),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .result_tag    (result_tag),
        .request_done  (request_done),
        .pending_count (pending_count),
        .last_result   (last_result)
    );

endmodule
